[design/bb3_pkg.sv]
package bb3_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = 12;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // register indexes, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // s/9 == (s * 3641) >> 15 for every s below 32768
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int PROD_W     = 24;

  // results one pixel may cause, in the order they leave
  typedef enum logic [1:0] {
    RES_INNER  = 2'd0,  // (y-1, x-1)
    RES_RIGHT  = 2'd1,  // (y-1, x) at a row end
    RES_BOTTOM = 2'd2,  // (y, x-1) on the last row
    RES_CORNER = 2'd3   // (y, x), bottom-right of the frame
  } res_kind_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic             interior;
    logic [PIX_W-1:0] border;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] cur;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [3:0]       emit;
  } job_t;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

[design/box_blur_3x3_rgb_unit.sv]
// 3x3 box filter for 24-bit pixels (blue in the low byte, red in the high byte) streamed in
// raster order. While the job queue has room, a steady stream runs at one pixel per cycle;
// a pixel that closes a row, or any pixel of the last row, produces up to four result words,
// one per cycle from the output register while the output is ready, and the extra words are
// covered by a four-entry job queue that stalls the input when it fills. Interior results
// are the truncated per-channel mean of the nine neighbours; border pixels, and whole frames
// under three pixels wide or high, pass unchanged. Every result carries its row and column;
// tlast marks the final word caused by one input pixel, tuser the bottom-right pixel.
// Two line stores of MAX_WIDTH entries hold the previous rows; they are never cleared and
// no result depends on an entry not written in the current frame. Writing either size
// register restarts the frame at row 0, column 0; a size of zero acts as one and sizes
// beyond MAX_WIDTH or MAX_HEIGHT are clamped to them.
module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chan_blue, chan_green, chan_red
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_blue, out_green, out_red, out_row, out_col, zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // last_of_frame
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bb3_pkg::*;

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic              cfg_wr;

  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              head;
  logic              q_empty;
  logic [QCNT_W-1:0] q_count;

  logic [PIX_W-1:0]  out_pixel;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  bb3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_pixel     (s_axis_tdata),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (cfg_wr),
    .q_count      (q_count),
    .push         (push),
    .push_job     (push_job)
  );

  bb3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .count    (q_count)
  );

  bb3_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_pixel      (out_pixel),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_last_run   (m_axis_tlast),
    .out_last_frame (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_col, out_row, out_pixel};

endmodule

[design/bb3_front.sv]
module bb3_front #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bb3_pkg::PIX_W-1:0]   in_pixel,
  input  logic [bb3_pkg::FW_W-1:0]    frame_width,
  input  logic [bb3_pkg::FH_W-1:0]    frame_height,
  input  logic                        restart,
  input  logic [bb3_pkg::QCNT_W-1:0]  q_count,
  output logic                        push,
  output bb3_pkg::job_t               push_job
);
  import bb3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [AW-1:0]    col;
  logic [RW-1:0]    row;
  logic [AW-1:0]    w_last;
  logic [RW-1:0]    h_last;
  logic             last_col;
  logic             last_row;
  logic             accept;
  logic [3:0]       emit_next;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [AW-1:0]    s1_x;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [3:0]       s1_emit;
  logic             s1_interior;
  logic             s1_fwd;
  logic [PIX_W-1:0] fwd_top;
  logic [PIX_W-1:0] fwd_mid;
  logic [PIX_W-1:0] s1_top;
  logic [PIX_W-1:0] s1_mid;

  logic [PIX_W-1:0] store_upper  [MAX_WIDTH];
  logic [PIX_W-1:0] store_middle [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] middle_rd;

  logic [PIX_W-1:0] win [6];
  logic [SUM_W-1:0] sum_ch [3];

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(frame_width - 12'd1);
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(frame_height - 13'd1);
    end
  end

  assign last_col = (col >= w_last);
  assign last_row = (row >= h_last);
  assign in_ready = (q_count + QCNT_W'(s1_valid)) < QCNT_W'(QDEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    emit_next             = '0;
    emit_next[RES_INNER]  = (row != '0) && (col != '0);
    emit_next[RES_RIGHT]  = (row != '0) && last_col;
    emit_next[RES_BOTTOM] = last_row && (col != '0);
    emit_next[RES_CORNER] = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= in_pixel;
      s1_x        <= col;
      s1_row      <= ROW_W'(row);
      s1_col      <= COL_W'(col);
      s1_emit     <= emit_next;
      s1_interior <= (row > RW'(1)) && (col > AW'(1));
      // store write of the word ahead lands at the same edge as this read
      s1_fwd      <= s1_valid && (s1_x == col);
      fwd_top     <= s1_mid;
      fwd_mid     <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      store_upper[s1_x]  <= s1_mid;
      store_middle[s1_x] <= s1_pix;
    end
    upper_rd  <= store_upper[col];
    middle_rd <= store_middle[col];
  end

  assign s1_top = s1_fwd ? fwd_top : upper_rd;
  assign s1_mid = s1_fwd ? fwd_mid : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= s1_top;
      win[4] <= s1_mid;
      win[5] <= s1_pix;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_ch[k] = SUM_W'(s1_top[CH_W*k +: CH_W]) + SUM_W'(s1_mid[CH_W*k +: CH_W])
                + SUM_W'(s1_pix[CH_W*k +: CH_W]);
      for (int i = 0; i < 6; i++) begin
        sum_ch[k] = sum_ch[k] + SUM_W'(win[i][CH_W*k +: CH_W]);
      end
    end
  end

  assign push = s1_valid && (s1_emit != '0);

  always_comb begin
    push_job.sum_blue  = sum_ch[0];
    push_job.sum_green = sum_ch[1];
    push_job.sum_red   = sum_ch[2];
    push_job.interior  = s1_interior;
    push_job.border    = win[4];
    push_job.mid       = s1_mid;
    push_job.right     = win[5];
    push_job.cur       = s1_pix;
    push_job.row       = s1_row;
    push_job.col       = s1_col;
    push_job.emit      = s1_emit;
  end

`ifndef NO_ASSERTIONS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> (col == '0) && (row == '0))
    else $error("frame position not cleared by register write");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != QCNT_W'(QDEPTH)))
    else $error("job pushed into a full queue");
`endif

endmodule

[design/bb3_queue.sv]
module bb3_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bb3_pkg::job_t               push_job,
  input  logic                        pop,
  output bb3_pkg::job_t               head,
  output logic                        empty,
  output logic [bb3_pkg::QCNT_W-1:0]  count
);
  import bb3_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty job queue");
`endif

endmodule

[design/bb3_back.sv]
module bb3_back (
  input  logic                       clk,
  input  logic                       rst,
  input  bb3_pkg::job_t              head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bb3_pkg::PIX_W-1:0]  out_pixel,
  output logic [bb3_pkg::ROW_W-1:0]  out_row,
  output logic [bb3_pkg::COL_W-1:0]  out_col,
  output logic                       out_last_run,
  output logic                       out_last_frame
);
  import bb3_pkg::*;

  logic [3:0]       done;
  logic [3:0]       remaining;
  logic [3:0]       rest;
  res_kind_t        sel;
  logic             is_last;
  logic             load;
  logic [PIX_W-1:0] mean;
  logic [PIX_W-1:0] res_pixel;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic [ROW_W-1:0] row_up;
  logic [COL_W-1:0] col_left;

  assign remaining = head.emit & ~done;

  always_comb begin
    priority if (remaining[RES_INNER]) begin
      sel = RES_INNER;
    end else if (remaining[RES_RIGHT]) begin
      sel = RES_RIGHT;
    end else if (remaining[RES_BOTTOM]) begin
      sel = RES_BOTTOM;
    end else begin
      sel = RES_CORNER;
    end
    rest    = remaining & ~(4'b0001 << sel);
    is_last = (rest == '0);
  end

  assign load = !empty && (!out_valid || out_ready);
  assign pop  = load && is_last;

  assign mean     = {div9(head.sum_red), div9(head.sum_green), div9(head.sum_blue)};
  assign row_up   = head.row - ROW_W'(1);
  assign col_left = head.col - COL_W'(1);

  always_comb begin
    unique case (sel)
      RES_INNER: begin
        res_pixel = head.interior ? mean : head.border;
        res_row   = row_up;
        res_col   = col_left;
      end
      RES_RIGHT: begin
        res_pixel = head.mid;
        res_row   = row_up;
        res_col   = head.col;
      end
      RES_BOTTOM: begin
        res_pixel = head.right;
        res_row   = head.row;
        res_col   = col_left;
      end
      RES_CORNER: begin
        res_pixel = head.cur;
        res_row   = head.row;
        res_col   = head.col;
      end
      default: begin
        res_pixel = head.cur;
        res_row   = head.row;
        res_col   = head.col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= is_last ? '0 : (done | (4'b0001 << sel));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel      <= res_pixel;
      out_row        <= res_row;
      out_col        <= res_col;
      out_last_run   <= is_last;
      out_last_frame <= (sel == RES_CORNER);
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last_frame |-> out_last_run)
    else $error("frame end word not last of its run");

  a_done_within_job: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((done & ~head.emit) == '0))
    else $error("sent-result mask outside the job's results");
`endif

endmodule
